[rtl/alc_pkg.sv]
// ----------------------------------------------------------------------------
// alc_pkg
// Shared constants, codes and types of the fit policy block allocator.
// ----------------------------------------------------------------------------
package alc_pkg;

  localparam int unsigned MAX_BLOCKS = 16;
  localparam int unsigned SIZE_BITS  = 16;
  localparam int unsigned IDX_BITS   = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_BITS   = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned MODE_BITS  = 2;
  localparam int unsigned CFG_BITS   = 5;
  localparam int unsigned CFG_IDX_BITS = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIT_MODE    = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_COUNT = 1'd1;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_RESTART = 2'd1,
    OP_ALLOC   = 2'd2
  } op_e;

  typedef enum logic [MODE_BITS-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_COPY,
    ST_SCAN,
    ST_PLACE,
    ST_DONE
  } state_e;

  // write controls of the capacity tables
  typedef struct packed {
    logic                 orig_we;
    logic [IDX_BITS-1:0]  orig_idx;
    logic [SIZE_BITS-1:0] orig_data;
    logic                 rem_we;
    logic [IDX_BITS-1:0]  rem_idx;
    logic [SIZE_BITS-1:0] rem_data;
  } store_wr_t;

  // verdict of the compare unit for one scanned block
  typedef struct packed {
    logic fits;
    logic take;
  } fit_res_t;

endpackage

[rtl/alc_cap_store.sv]
// ----------------------------------------------------------------------------
// alc_cap_store
// Original and remaining capacity tables, one write port each.
// ----------------------------------------------------------------------------
module alc_cap_store (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  alc_pkg::store_wr_t             wr_i,
  input  logic [alc_pkg::IDX_BITS-1:0]   orig_raddr_i,
  output logic [alc_pkg::SIZE_BITS-1:0]  orig_rdata_o,
  input  logic [alc_pkg::IDX_BITS-1:0]   rem_raddr_i,
  output logic [alc_pkg::SIZE_BITS-1:0]  rem_rdata_o
);
  import alc_pkg::*;

  logic [SIZE_BITS-1:0]  orig_q [MAX_BLOCKS];
  logic [SIZE_BITS-1:0]  rem_q  [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] rem_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.orig_we) begin
      orig_q[wr_i.orig_idx] <= wr_i.orig_data;
    end
    if (wr_i.rem_we) begin
      rem_q[wr_i.rem_idx] <= wr_i.rem_data;
    end
  end

  // remaining entries read as zero until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_vld_q <= '0;
    end else if (wr_i.rem_we) begin
      rem_vld_q[wr_i.rem_idx] <= 1'b1;
    end
  end

  assign orig_rdata_o = orig_q[orig_raddr_i];
  assign rem_rdata_o  = rem_vld_q[rem_raddr_i] ? rem_q[rem_raddr_i] : '0;

endmodule

[rtl/alc_fit_unit.sv]
// ----------------------------------------------------------------------------
// alc_fit_unit
// Shared compare and subtract unit used once per scanned block.
// ----------------------------------------------------------------------------
module alc_fit_unit (
  input  alc_pkg::fit_e                  mode_i,
  input  logic [alc_pkg::SIZE_BITS-1:0]  cap_i,
  input  logic [alc_pkg::SIZE_BITS-1:0]  request_i,
  input  logic                           found_i,
  input  logic [alc_pkg::SIZE_BITS-1:0]  best_cap_i,
  output alc_pkg::fit_res_t              res_o,
  output logic [alc_pkg::SIZE_BITS-1:0]  left_o
);
  import alc_pkg::*;

  logic better;

  always_comb begin
    unique case (mode_i)
      FIT_FIRST: better = !found_i;
      FIT_BEST:  better = !found_i || (cap_i < best_cap_i);
      FIT_WORST: better = !found_i || (cap_i > best_cap_i);
      default:   better = 1'b0;
    endcase
  end

  assign res_o.fits = (cap_i >= request_i);
  assign res_o.take = res_o.fits && better;
  assign left_o     = best_cap_i - request_i;

endmodule

[rtl/fit_policy_block_allocator_core.sv]
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_core
// Block allocator with first, best and worst fit placement policies.
// ----------------------------------------------------------------------------
// steps: load writes an original, restart copies originals, allocate scans then places
// throughput: one transfer at a time; the scan reads one block per cycle
//   through the shared compare unit
// reset: control registers clear to zero, remaining capacities read as zero,
//   original capacities hold garbage until loaded
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [alc_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  logic [alc_pkg::CFG_BITS-1:0]     cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // block_index[3:0], amount[19:4], zero pad
  input  logic [1:0]  s_axis_tuser_i,   // op[1:0]
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // chosen_block[3:0], left_over[19:4], zero pad
  output logic [0:0]  m_axis_tuser_o    // granted[0]
);
  import alc_pkg::*;

  // configuration registers
  logic [MODE_BITS-1:0] fit_mode_q;
  logic [CNT_BITS-1:0]  block_count_q;

  // latched request
  logic [IDX_BITS-1:0]  idx_q;
  logic [SIZE_BITS-1:0] amt_q;

  // sequencer state
  state_e               state_q, state_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic                 found_q, found_d;
  logic [IDX_BITS-1:0]  best_idx_q, best_idx_d;
  logic [SIZE_BITS-1:0] best_cap_q, best_cap_d;

  // pending result
  logic                 res_gnt_q, res_gnt_d;
  logic [IDX_BITS-1:0]  res_blk_q, res_blk_d;
  logic [SIZE_BITS-1:0] res_left_q, res_left_d;

  // output register
  logic                 m_vld_q, m_vld_d;
  logic                 m_gnt_q;
  logic [IDX_BITS-1:0]  m_blk_q;
  logic [SIZE_BITS-1:0] m_left_q;

  logic                 in_xfer;
  logic                 out_free;
  logic                 load_out;
  logic [CNT_BITS-1:0]  n_used;
  logic                 scan_end;
  logic                 copy_end;

  store_wr_t            wr;
  logic [SIZE_BITS-1:0] orig_rdata;
  logic [SIZE_BITS-1:0] rem_rdata;
  fit_res_t             fit_res;
  logic [SIZE_BITS-1:0] fit_left;

  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_vld_q || m_axis_tready_i;

  // blocks in use saturate at the table depth
  assign n_used   = (block_count_q > CNT_BITS'(MAX_BLOCKS)) ? CNT_BITS'(MAX_BLOCKS)
                                                            : block_count_q;
  assign scan_end = (cnt_q >= n_used);
  assign copy_end = (cnt_q == CNT_BITS'(MAX_BLOCKS - 1));

  alc_cap_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_i         (wr),
    .orig_raddr_i (cnt_q[IDX_BITS-1:0]),
    .orig_rdata_o (orig_rdata),
    .rem_raddr_i  (cnt_q[IDX_BITS-1:0]),
    .rem_rdata_o  (rem_rdata)
  );

  alc_fit_unit u_fit (
    .mode_i     (fit_e'(fit_mode_q)),
    .cap_i      (rem_rdata),
    .request_i  (amt_q),
    .found_i    (found_q),
    .best_cap_i (best_cap_q),
    .res_o      (fit_res),
    .left_o     (fit_left)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          unique case (op_e'(s_axis_tuser_i))
            OP_LOAD:    state_d = ST_LOAD;
            OP_RESTART: state_d = ST_COPY;
            OP_ALLOC:   state_d = ST_SCAN;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_LOAD:  state_d = ST_DONE;
      ST_COPY: begin
        if (copy_end) begin
          state_d = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs and datapath next values
  always_comb begin
    s_axis_tready_o = 1'b0;
    load_out        = 1'b0;
    cnt_d           = cnt_q;
    found_d         = found_q;
    best_idx_d      = best_idx_q;
    best_cap_d      = best_cap_q;
    res_gnt_d       = res_gnt_q;
    res_blk_d       = res_blk_q;
    res_left_d      = res_left_q;
    wr              = '0;
    wr.orig_idx     = idx_q;
    wr.orig_data    = amt_q;
    wr.rem_idx      = cnt_q[IDX_BITS-1:0];
    wr.rem_data     = orig_rdata;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        cnt_d           = '0;
        found_d         = 1'b0;
        best_idx_d      = '0;
        best_cap_d      = '0;
        res_gnt_d       = 1'b0;
        res_blk_d       = '0;
        res_left_d      = '0;
      end
      ST_LOAD: begin
        wr.orig_we = 1'b1;
      end
      ST_COPY: begin
        // one entry per cycle from originals into remaining
        wr.rem_we = 1'b1;
        cnt_d     = cnt_q + 1'b1;
      end
      ST_SCAN: begin
        if (!scan_end) begin
          cnt_d = cnt_q + 1'b1;
          if (fit_res.take) begin
            found_d    = 1'b1;
            best_idx_d = cnt_q[IDX_BITS-1:0];
            best_cap_d = rem_rdata;
          end
        end
      end
      ST_PLACE: begin
        // write back the reduced capacity of the chosen block
        if (found_q) begin
          wr.rem_we   = 1'b1;
          wr.rem_idx  = best_idx_q;
          wr.rem_data = fit_left;
          res_gnt_d   = 1'b1;
          res_blk_d   = best_idx_q;
          res_left_d  = fit_left;
        end
      end
      ST_DONE: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    m_vld_d = m_vld_q;
    if (load_out) begin
      m_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_vld_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      m_vld_q       <= 1'b0;
      fit_mode_q    <= '0;
      block_count_q <= '0;
    end else begin
      state_q <= state_d;
      m_vld_q <= m_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FIT_MODE:    fit_mode_q    <= cfg_data_i[MODE_BITS-1:0];
          CFG_BLOCK_COUNT: block_count_q <= cfg_data_i[CNT_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      idx_q <= s_axis_tdata_i[IDX_BITS-1:0];
      amt_q <= s_axis_tdata_i[IDX_BITS +: SIZE_BITS];
    end
    cnt_q      <= cnt_d;
    found_q    <= found_d;
    best_idx_q <= best_idx_d;
    best_cap_q <= best_cap_d;
    res_gnt_q  <= res_gnt_d;
    res_blk_q  <= res_blk_d;
    res_left_q <= res_left_d;
    if (load_out) begin
      m_gnt_q  <= res_gnt_q;
      m_blk_q  <= res_blk_q;
      m_left_q <= res_left_q;
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = {{(24 - IDX_BITS - SIZE_BITS){1'b0}}, m_left_q, m_blk_q};
  assign m_axis_tuser_o  = m_gnt_q;

endmodule
